### design/softmax_forward_top_macros.svh
// Assertion macros used by the softmax port checker.
`ifndef SOFTMAX_FORWARD_TOP_MACROS_SVH
`define SOFTMAX_FORWARD_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define SFM_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("softmax_forward: same-cycle check failed");

// Next-cycle implication, disabled while reset is held
`define SFM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("softmax_forward: next-cycle check failed");

// Next-cycle implication that also holds through reset
`define SFM_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("softmax_forward: reset check failed");

`endif

### design/sfm_pkg.sv
// Shared constants, types and the exp table for the softmax block.
package sfm_pkg;

    localparam int SCORE_W          = 16;
    localparam int PROB_W           = 16;
    localparam int EXP_W            = 17;
    localparam int SUM_W            = 24;
    localparam int PROD_W           = 32;
    localparam int MAX_ELEMENTS_DEF = 64;
    localparam int DIV_STEPS        = 17;
    localparam int DIV_CNT_W        = 5;
    localparam int SHIFT_LIMIT      = 17;

    // log2(e) in Q1.15
    localparam logic [15:0] LOG2E_Q15 = 16'd47274;

    // Most negative Q8.8 score, reset value of the running maximum
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = 16'sh8000;

    // Registered memory read
    typedef struct packed {
        logic                      valid;
        logic signed [SCORE_W-1:0] data;
    } rd_data_t;

    // Exp unit result
    typedef struct packed {
        logic             valid;
        logic [EXP_W-1:0] value;
    } exp_out_t;

    // round(65536 * 2^(-f/16)), Q1.16
    function automatic logic [EXP_W-1:0] pow2_frac(input logic [3:0] f);
        logic [EXP_W-1:0] v;
        case (f)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd62757;
            4'd2:    v = 17'd60097;
            4'd3:    v = 17'd57549;
            4'd4:    v = 17'd55109;
            4'd5:    v = 17'd52773;
            4'd6:    v = 17'd50535;
            4'd7:    v = 17'd48393;
            4'd8:    v = 17'd46341;
            4'd9:    v = 17'd44376;
            4'd10:   v = 17'd42495;
            4'd11:   v = 17'd40693;
            4'd12:   v = 17'd38968;
            4'd13:   v = 17'd37316;
            4'd14:   v = 17'd35734;
            default: v = 17'd34219;
        endcase
        return v;
    endfunction

endpackage

### design/softmax_forward_top.sv
// Softmax block top level: load, sum and emit control around the score store.
//
// Usage: scores (signed Q8.8) arrive on the s_ stream, one per transaction;
// s_tlast marks the final element of a vector. A vector of MAX_ELEMENTS
// elements is closed even without s_tlast. Probabilities (unsigned Q0.16,
// truncated, saturated at 65535) leave on the m_ stream in arrival order,
// m_tlast on the final one.
// Loading takes one element per cycle while s_tvalid is high. After the
// closing element the block reads the store once to sum exp(x - max), then
// reads it again and emits the probabilities one at a time: each element
// passes the memory read, two exp stages and the 17-step restoring divider
// before the next is read. s_tready is low from the closing element until
// the final probability sits in the output register.
// Reset (synchronous, aresetn low) empties the vector and clears the output
// valid flag; store contents are not cleared and need not be.
// A stalled receiver holds the result in the output register; the divider
// finishes the next element and waits for the register to drain.
module softmax_forward_top #(
    parameter int MAX_ELEMENTS = sfm_pkg::MAX_ELEMENTS_DEF,
    parameter int AW           = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1,
    parameter int CW           = $clog2(MAX_ELEMENTS + 1)
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] score
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] probability
    output logic        m_tlast    // last_out
);

    localparam logic [2:0] ST_LOAD      = 3'd0;
    localparam logic [2:0] ST_SUM       = 3'd1;
    localparam logic [2:0] ST_EMIT_RD   = 3'd2;
    localparam logic [2:0] ST_EMIT_WAIT = 3'd3;
    localparam logic [2:0] ST_EMIT_DIV  = 3'd4;
    localparam logic [2:0] ST_EMIT_OUT  = 3'd5;

    logic [2:0]                         state_reg, state_next;
    logic [CW-1:0]                      count_reg, count_next;
    logic [CW-1:0]                      rd_idx_reg, rd_idx_next;
    logic [CW-1:0]                      acc_idx_reg, acc_idx_next;
    logic signed [sfm_pkg::SCORE_W-1:0] max_reg, max_next;
    logic [sfm_pkg::SUM_W-1:0]          sum_reg, sum_next;
    logic                               out_valid_reg, out_valid_next;
    logic [sfm_pkg::PROB_W-1:0]         out_prob_reg, out_prob_next;
    logic                               out_last_reg, out_last_next;

    logic                               in_fire;
    logic signed [sfm_pkg::SCORE_W-1:0] score;
    logic [CW-1:0]                      count_inc;
    logic [CW-1:0]                      acc_inc;
    logic [CW-1:0]                      rd_inc;
    logic                               rd_en;
    logic                               out_free;
    logic                               div_start;
    logic                               div_done;
    logic [sfm_pkg::PROB_W-1:0]         div_q;
    sfm_pkg::rd_data_t                  rd;
    sfm_pkg::exp_out_t                  exp_out;

    assign score     = s_tdata;
    assign s_tready  = (state_reg == ST_LOAD);
    assign in_fire   = s_tvalid && s_tready;
    assign count_inc = count_reg + 1'b1;
    assign acc_inc   = acc_idx_reg + 1'b1;
    assign rd_inc    = rd_idx_reg + 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign rd_en     = ((state_reg == ST_SUM) && (rd_idx_reg < count_reg))
                    || (state_reg == ST_EMIT_RD);
    assign div_start = (state_reg == ST_EMIT_WAIT) && exp_out.valid;

    sfm_score_mem #(
        .DEPTH (MAX_ELEMENTS),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (in_fire),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (score),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg[AW-1:0]),
        .rd      (rd)
    );

    sfm_exp_unit u_exp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in        (rd),
        .max_score (max_reg),
        .out       (exp_out)
    );

    sfm_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (exp_out.value),
        .divisor  (sum_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Sequencer: load, sum pass, per-element emit
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        acc_idx_next   = acc_idx_reg;
        max_next       = max_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_prob_next  = out_prob_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            ST_LOAD: begin
                if (in_fire) begin
                    count_next = count_inc;
                    if (score > max_reg) begin
                        max_next = score;
                    end
                    if (s_tlast || (count_inc == CW'(MAX_ELEMENTS))) begin
                        state_next   = ST_SUM;
                        rd_idx_next  = '0;
                        acc_idx_next = '0;
                        sum_next     = '0;
                    end
                end
            end
            ST_SUM: begin
                if (rd_en) begin
                    rd_idx_next = rd_inc;
                end
                if (exp_out.valid) begin
                    sum_next     = sum_reg + sfm_pkg::SUM_W'(exp_out.value);
                    acc_idx_next = acc_inc;
                    if (acc_inc == count_reg) begin
                        state_next  = ST_EMIT_RD;
                        rd_idx_next = '0;
                    end
                end
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT: begin
                if (exp_out.valid) begin
                    state_next = ST_EMIT_DIV;
                end
            end
            ST_EMIT_DIV: begin
                if (div_done) begin
                    state_next = ST_EMIT_OUT;
                end
            end
            ST_EMIT_OUT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_prob_next  = div_q;
                    out_last_next  = (rd_inc == count_reg);
                    if (rd_inc == count_reg) begin
                        state_next = ST_LOAD;
                        count_next = '0;
                        max_next   = sfm_pkg::SCORE_MIN;
                        sum_next   = '0;
                    end else begin
                        state_next  = ST_EMIT_RD;
                        rd_idx_next = rd_inc;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            acc_idx_reg   <= '0;
            max_reg       <= sfm_pkg::SCORE_MIN;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            acc_idx_reg   <= acc_idx_next;
            max_reg       <= max_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        out_prob_reg <= out_prob_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_prob_reg;
    assign m_tlast  = out_last_reg;

endmodule

### design/sfm_score_mem.sv
// Score store: single-write, single-read synchronous memory with a registered read.
module sfm_score_mem #(
    parameter int DEPTH = sfm_pkg::MAX_ELEMENTS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              wr_en,
    input  logic [AW-1:0]                     wr_addr,
    input  logic signed [sfm_pkg::SCORE_W-1:0] wr_data,
    input  logic                              rd_en,
    input  logic [AW-1:0]                     rd_addr,
    output sfm_pkg::rd_data_t                 rd
);

    logic signed [sfm_pkg::SCORE_W-1:0] mem [DEPTH];
    logic signed [sfm_pkg::SCORE_W-1:0] rd_data_reg;
    logic                               rd_valid_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= rd_en;
        end
    end

    assign rd.valid = rd_valid_reg;
    assign rd.data  = rd_data_reg;

endmodule

### design/sfm_exp_unit.sv
// Two-stage exp(x - max): log2(e) multiply, then power-of-two table and shift.
module sfm_exp_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  sfm_pkg::rd_data_t                  in,
    input  logic signed [sfm_pkg::SCORE_W-1:0] max_score,
    output sfm_pkg::exp_out_t                  out
);

    logic [sfm_pkg::SCORE_W:0]     diff;
    logic [sfm_pkg::PROD_W-1:0]    prod_next;
    logic [sfm_pkg::PROD_W-1:0]    prod_reg;
    logic                          v1_reg;
    logic [16:0]                   t_val;
    logic [8:0]                    k_val;
    logic [3:0]                    f_val;
    logic [sfm_pkg::EXP_W-1:0]     e_next;
    logic [sfm_pkg::EXP_W-1:0]     e_reg;
    logic                          v2_reg;

    // Stage 1: d = max - x (never negative), times log2(e)
    always_comb begin
        diff      = {max_score[sfm_pkg::SCORE_W-1], max_score}
                  - {in.data[sfm_pkg::SCORE_W-1], in.data};
        prod_next = sfm_pkg::PROD_W'(diff[sfm_pkg::SCORE_W-1:0])
                  * sfm_pkg::PROD_W'(sfm_pkg::LOG2E_Q15);
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        e_reg    <= e_next;
    end

    // Stage 2: t = prod >> 15, integer part shifts, fraction picks the table entry
    always_comb begin
        t_val = prod_reg[31:15];
        k_val = t_val[16:8];
        f_val = t_val[7:4];
        if (k_val >= 9'(sfm_pkg::SHIFT_LIMIT)) begin
            e_next = '0;
        end else begin
            e_next = sfm_pkg::pow2_frac(f_val) >> k_val[4:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= in.valid;
            v2_reg <= v1_reg;
        end
    end

    assign out.valid = v2_reg;
    assign out.value = e_reg;

endmodule

### design/sfm_divider.sv
// Restoring divider: (e << 16) / sum, one quotient bit per cycle, saturated to 16 bits.
module sfm_divider (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [sfm_pkg::EXP_W-1:0]      dividend,
    input  logic [sfm_pkg::SUM_W-1:0]      divisor,
    output logic                           done,
    output logic [sfm_pkg::PROB_W-1:0]     quotient
);

    logic [sfm_pkg::SUM_W-1:0]     rem_reg;
    logic [sfm_pkg::SUM_W-1:0]     rem_next;
    logic [sfm_pkg::SUM_W-1:0]     rem_sub;
    logic [sfm_pkg::SUM_W-1:0]     div_reg;
    logic [sfm_pkg::EXP_W-1:0]     q_reg;
    logic [sfm_pkg::EXP_W-1:0]     q_next;
    logic [sfm_pkg::DIV_CNT_W-1:0] step_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic                          ge;

    // One trial subtraction; remainder stays below the divisor, so the shift cannot overflow
    always_comb begin
        ge       = (rem_reg >= div_reg);
        rem_sub  = ge ? (rem_reg - div_reg) : rem_reg;
        rem_next = {rem_sub[sfm_pkg::SUM_W-2:0], 1'b0};
        q_next   = {q_reg[sfm_pkg::EXP_W-2:0], ge};
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= sfm_pkg::SUM_W'(dividend);
            div_reg <= divisor;
            q_reg   <= '0;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    // Step control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == sfm_pkg::DIV_CNT_W'(sfm_pkg::DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // A quotient of exactly one saturates
    assign quotient = q_reg[sfm_pkg::EXP_W-1] ? '1 : q_reg[sfm_pkg::PROB_W-1:0];
    assign done     = done_reg;

endmodule

### design/sfm_port_checker.sv
// Port-level checks for the softmax block, bound to the top level.
`include "softmax_forward_top_macros.svh"

module sfm_port_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // Nothing is offered on the result side right after reset
    `SFM_ASSERT_ALWAYS_NEXT(a_reset_clears_out, aclk, !aresetn, !m_tvalid)

    // A closing element stops intake for the sum pass
    `SFM_ASSERT_NEXT(a_last_stops_intake, aclk, aresetn, s_tvalid && s_tready && s_tlast, !s_tready)

    // No new vector is taken while a non-final probability waits
    `SFM_ASSERT_NOW(a_no_intake_mid_emit, aclk, aresetn, m_tvalid && !m_tlast, !s_tready)

    // A stalled result holds
    `SFM_ASSERT_NEXT(a_stall_holds, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

endmodule

bind softmax_forward_top sfm_port_checker u_port_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
